### rtl/mwpo_pkg.sv
// Shared types, constants and table builders for the multiwave phase oscillator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none
package mwpo_pkg;

    localparam int PHASE_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int SFRAC      = SAMPLE_W - 1;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int BASE_W     = 23;
    localparam int AMP_W      = 16;
    localparam int FREQ_W     = 24;
    localparam int FREQ_LIMIT = 6144000;
    localparam int EXP_STEPS  = 6;
    localparam logic [31:0] EXP_INIT = 32'd165394;

    // Enable bits of the cv_enables register.
    localparam int EN_EXP_FM = 0;
    localparam int EN_LIN_FM = 1;
    localparam int EN_AMP_CV = 2;
    localparam int EN_SYNC   = 3;
    localparam int EN_PWM    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_MODE   = 3'd0,
        REG_BASE_FREQ   = 3'd1,
        REG_AMPLITUDE   = 3'd2,
        REG_HZ_TO_PHASE = 3'd3,
        REG_CV_ENABLES  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_TRI    = 2'd3
    } t_wave;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROM, ST_WAVE, ST_AMP, ST_AMPCV, ST_OUT,
        ST_EXP, ST_BASE, ST_FREQ, ST_STEP, ST_ADV
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_TAKE, OP_ROM, OP_WAVE, OP_AMP, OP_AMPCV, OP_OUT,
        OP_EXP, OP_BASE, OP_FREQ, OP_STEP, OP_ADV
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    typedef logic signed [SAMPLE_W-1:0] t_rom [SINE_DEPTH];

    // Q30 coefficients of the 2^x Horner chain, after the initial value.
    function automatic logic [31:0] exp_coef(input logic [2:0] idx);
        logic [31:0] c;
        unique case (idx)
            3'd0:    c = 32'd1431680;
            3'd1:    c = 32'd10327388;
            3'd2:    c = 32'd59597083;
            3'd3:    c = 32'd257941248;
            3'd4:    c = 32'd744261118;
            3'd5:    c = 32'd1073741824;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    // Full sine table, built at elaboration from a quarter-wave polynomial.
    function automatic t_rom sine_rom_build();
        t_rom        rom;
        logic [63:0] q4, quad, rem, t, u, b, r, v;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            q4   = 64'(4 * k);
            quad = q4 / SINE_DEPTH;
            rem  = q4 - quad * SINE_DEPTH;
            t    = (rem << 30) / SINE_DEPTH;
            if (quad[0])
                t = 64'd1073741824 - t;
            u = (t * t) >> 30;
            b = 64'd3864;
            b = 64'd172272 - ((u * b) >> 30);
            b = 64'd5026995 - ((u * b) >> 30);
            b = 64'd85569306 - ((u * b) >> 30);
            b = 64'd693598668 - ((u * b) >> 30);
            b = 64'd1686629713 - ((u * b) >> 30);
            r = (t * b) >> 30;
            v = (r + (64'd1 << (29 - SFRAC))) >> (30 - SFRAC);
            if (v > (64'd1 << SFRAC) - 64'd1)
                v = (64'd1 << SFRAC) - 64'd1;
            if (quad[1])
                v = 64'd0 - v;
            rom[k] = v[SAMPLE_W-1:0];
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

### rtl/mwpo_in_if.sv
// Input channel: valid/ready handshake carrying the five control voltages.
// Depends on mwpo_pkg for the sample width.
`default_nettype none
interface mwpo_in_if;
    import mwpo_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] exp_fm_cv;
    logic signed [SAMPLE_W-1:0] lin_fm_cv;
    logic signed [SAMPLE_W-1:0] amp_cv;
    logic signed [SAMPLE_W-1:0] sync_cv;
    logic signed [SAMPLE_W-1:0] pwm_cv;

    modport source (output valid, exp_fm_cv, lin_fm_cv, amp_cv, sync_cv, pwm_cv,
                    input ready);
    modport sink   (input valid, exp_fm_cv, lin_fm_cv, amp_cv, sync_cv, pwm_cv,
                    output ready);
endinterface
`default_nettype wire

### rtl/mwpo_out_if.sv
// Output channel: valid/ready handshake carrying one output sample.
// Depends on mwpo_pkg for the sample width.
`default_nettype none
interface mwpo_out_if;
    import mwpo_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface
`default_nettype wire

### rtl/mwpo_ctrl.sv
// Sequencer of the oscillator: steps the datapath through one sample's work.
// Depends on mwpo_pkg for the state, command and status types.
`default_nettype none
module mwpo_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  mwpo_pkg::t_status     i_status,
    output mwpo_pkg::t_cmd        o_cmd
);
    import mwpo_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_ROM;
            ST_ROM:   n_state = ST_WAVE;
            ST_WAVE:  n_state = ST_AMP;
            ST_AMP:   n_state = ST_AMPCV;
            ST_AMPCV: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_status.out_busy) begin
                    n_state = ST_EXP;
                    n_cnt   = '0;
                end
            end
            ST_EXP: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'(EXP_STEPS - 1))
                    n_state = ST_BASE;
            end
            ST_BASE:  n_state = ST_FREQ;
            ST_FREQ:  n_state = ST_STEP;
            ST_STEP:  n_state = ST_ADV;
            ST_ADV:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_TAKE;
            end
            ST_ROM:   o_cmd.op = OP_ROM;
            ST_WAVE:  o_cmd.op = OP_WAVE;
            ST_AMP:   o_cmd.op = OP_AMP;
            ST_AMPCV: o_cmd.op = OP_AMPCV;
            ST_OUT:   if (!i_status.out_busy) o_cmd.op = OP_OUT;
            ST_EXP:   o_cmd.op = OP_EXP;
            ST_BASE:  o_cmd.op = OP_BASE;
            ST_FREQ:  o_cmd.op = OP_FREQ;
            ST_STEP:  o_cmd.op = OP_STEP;
            ST_ADV:   o_cmd.op = OP_ADV;
            default:  o_cmd.op = OP_NONE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/mwpo_dp.sv
// Datapath of the oscillator: registers, phase, sine ROM, shared multiplier,
// frequency and output logic. Depends on mwpo_pkg; driven by mwpo_ctrl.
`default_nettype none
module mwpo_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mwpo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mwpo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic signed [mwpo_pkg::SAMPLE_W-1:0] i_exp_fm_cv,
    input  wire logic signed [mwpo_pkg::SAMPLE_W-1:0] i_lin_fm_cv,
    input  wire logic signed [mwpo_pkg::SAMPLE_W-1:0] i_amp_cv,
    input  wire logic signed [mwpo_pkg::SAMPLE_W-1:0] i_sync_cv,
    input  wire logic signed [mwpo_pkg::SAMPLE_W-1:0] i_pwm_cv,
    input  mwpo_pkg::t_cmd                           i_cmd,
    output mwpo_pkg::t_status                        o_status,
    output logic                                     o_out_valid,
    output logic signed [mwpo_pkg::SAMPLE_W-1:0]     o_sample_out,
    input  wire logic                                i_out_ready
);
    import mwpo_pkg::*;

    localparam t_rom SINE_ROM = sine_rom_build();
    localparam int   FS       = 1 << SFRAC;

    logic [1:0]                r_wave_mode;
    logic [BASE_W-1:0]         r_base;
    logic [AMP_W-1:0]          r_amp;
    logic [31:0]               r_hz;
    logic [4:0]                r_cven;
    logic [PHASE_W-1:0]        r_phase;
    logic                      r_sync_hi;
    logic signed [SAMPLE_W-1:0] r_lin_cv, r_amp_cv, r_pwm_cv, r_sine;
    logic [14:0]               r_frac;
    logic [4:0]                r_nb;
    logic signed [SAMPLE_W:0]  r_w;
    logic                      r_neg;
    logic [63:0]               r_prod;
    logic [31:0]               r_acc;
    logic signed [FREQ_W-1:0]  r_freq;
    logic                      r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [31:0]               mul_a, mul_b;
    logic [63:0]               mul_p;
    logic [19:0]               eb;
    logic [SAMPLE_W:0]         w_mag;
    logic [FREQ_W-2:0]         f_mag;
    logic signed [SAMPLE_W:0]  w_next;
    logic signed [18:0]        tri_v;
    logic [16:0]               tri_q;
    logic [31:0]               sq_thr;
    logic signed [48:0]        y_full, y_sh;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic [5:0]                exp_sh;
    logic [63:0]               f_exp;
    logic signed [35:0]        f_sum, lin_t;

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_out;

    assign w_mag = r_w[SAMPLE_W] ? (SAMPLE_W+1)'(-r_w) : r_w;
    assign f_mag = r_freq[FREQ_W-1] ? (FREQ_W-1)'(-r_freq) : r_freq[FREQ_W-2:0];

    // Shared multiplier; operands are all magnitudes, signs are handled around it.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_AMP: begin
                mul_a = 32'(w_mag);
                mul_b = 32'(r_amp);
            end
            OP_AMPCV: begin
                mul_a = r_prod[31:0];
                mul_b = r_amp_cv[SAMPLE_W-1] ? 32'(-33'(r_amp_cv)) : 32'(r_amp_cv);
            end
            OP_EXP: begin
                mul_a = r_acc;
                mul_b = 32'(r_frac);
            end
            OP_BASE: begin
                mul_a = 32'(r_base);
                mul_b = r_acc;
            end
            OP_STEP: begin
                mul_a = 32'(f_mag);
                mul_b = r_hz;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign eb = 20'(32'(i_exp_fm_cv) * 32'sd10 + 32'sd327680);

    // Wave value from the current phase.
    always_comb begin
        sq_thr = r_cven[EN_PWM] ? {~r_pwm_cv[SAMPLE_W-1], r_pwm_cv[SAMPLE_W-2:0], 16'd0}
                                : 32'h8000_0000;
        tri_q  = r_phase[PHASE_W-1:15];
        if (r_phase <= 32'h8000_0000)
            tri_v = 19'(tri_q) - 19'(FS);
        else
            tri_v = 19'(3 * FS) - 19'(tri_q);
        unique case (t_wave'(r_wave_mode))
            WAVE_SINE:   w_next = (SAMPLE_W+1)'(r_sine);
            WAVE_SQUARE: w_next = (r_phase >= sq_thr) ? (SAMPLE_W+1)'(FS)
                                                      : -(SAMPLE_W+1)'(FS);
            WAVE_SAW:    w_next = (SAMPLE_W+1)'({1'b0, r_phase[PHASE_W-1:16]})
                                  - (SAMPLE_W+1)'(FS);
            default:     w_next = tri_v[SAMPLE_W:0];
        endcase
    end

    // Output scaling with floor shift and saturation.
    always_comb begin
        y_full = r_neg ? -49'(r_prod[47:0]) : 49'(r_prod[47:0]);
        y_sh   = r_cven[EN_AMP_CV] ? (y_full >>> 30) : (y_full >>> 15);
        if (y_sh > 49'(FS - 1))
            y_sat = SAMPLE_W'(FS - 1);
        else if (y_sh < -49'(FS))
            y_sat = SAMPLE_W'(-FS);
        else
            y_sat = y_sh[SAMPLE_W-1:0];
    end

    // Frequency after FM, before the clamp.
    always_comb begin
        exp_sh = 6'd40 - 6'(r_nb);
        f_exp  = r_prod >> exp_sh;
        lin_t  = (36'(r_lin_cv) * 36'sd125) >>> 1;
        f_sum  = (r_cven[EN_EXP_FM] ? 36'(f_exp[33:0]) : 36'(r_base))
                 + (r_cven[EN_LIN_FM] ? lin_t : 36'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= 2'd0;
            r_base      <= 23'd112640;
            r_amp       <= 16'd32768;
            r_hz        <= 32'd22906492;
            r_cven      <= 5'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WAVE_MODE:   r_wave_mode <= i_cfg_data[1:0];
                REG_BASE_FREQ:   r_base      <= i_cfg_data[BASE_W-1:0];
                REG_AMPLITUDE:   r_amp       <= i_cfg_data[AMP_W-1:0];
                REG_HZ_TO_PHASE: r_hz        <= i_cfg_data;
                REG_CV_ENABLES:  r_cven      <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_sync_hi   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            unique case (i_cmd.op)
                OP_TAKE: begin
                    if (r_cven[EN_SYNC]) begin
                        if (i_sync_cv > 0 && !r_sync_hi)
                            r_phase <= '0;
                        r_sync_hi <= (i_sync_cv > 0);
                    end
                end
                OP_OUT:  r_out_valid <= 1'b1;
                OP_ADV: begin
                    if (r_freq[FREQ_W-1])
                        r_phase <= r_phase - r_prod[47:16];
                    else
                        r_phase <= r_phase + r_prod[47:16];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_TAKE: begin
                r_lin_cv <= i_lin_fm_cv;
                r_amp_cv <= i_amp_cv;
                r_pwm_cv <= i_pwm_cv;
                r_frac   <= eb[14:0];
                r_nb     <= eb[19:15];
                r_acc    <= EXP_INIT;
            end
            OP_ROM:  r_sine <= SINE_ROM[r_phase[PHASE_W-1 -: SINE_AW]];
            OP_WAVE: r_w <= w_next;
            OP_AMP: begin
                r_prod <= mul_p;
                r_neg  <= r_w[SAMPLE_W];
            end
            OP_AMPCV: begin
                if (r_cven[EN_AMP_CV]) begin
                    r_prod <= mul_p;
                    r_neg  <= r_neg ^ r_amp_cv[SAMPLE_W-1];
                end
            end
            OP_OUT:  r_out  <= y_sat;
            OP_EXP:  r_acc  <= exp_coef(i_cmd.idx) + mul_p[46:15];
            OP_BASE: r_prod <= mul_p;
            OP_FREQ: begin
                if (f_sum > 36'sd6144000)
                    r_freq <= FREQ_W'(FREQ_LIMIT);
                else if (f_sum < -36'sd6144000)
                    r_freq <= FREQ_W'(-FREQ_LIMIT);
                else
                    r_freq <= f_sum[FREQ_W-1:0];
            end
            OP_STEP: r_prod <= mul_p;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### rtl/multiwave_phase_oscillator.sv
// Top level of the multiwave phase oscillator: joins controller and datapath.
// Depends on mwpo_pkg, mwpo_in_if, mwpo_out_if, mwpo_ctrl and mwpo_dp.
//
//   channel  direction  transfer condition
//   i_in     in         i_in.valid && i_in.ready: five control voltages
//   o_out    out        o_out.valid && o_out.ready: one saturated sample
//   cfg      in         i_cfg_we: register i_cfg_idx gets i_cfg_data
//
// A new input is taken only when the previous sample's work is done. That work
// is serialised by the single shared 32x32 multiplier used for gain, the six
// 2^x Horner steps, the base scaling and the phase step. The sample is written
// to the output register in OUT, after ROM, WAVE, AMP and AMPCV; a stalled
// output holds the sequencer before the frequency steps. Reset is synchronous.
`default_nettype none
module multiwave_phase_oscillator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mwpo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mwpo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mwpo_in_if.sink                              i_in,
    mwpo_out_if.source                           o_out
);
    import mwpo_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready = in_ready;

    mwpo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mwpo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_exp_fm_cv  (i_in.exp_fm_cv),
        .i_lin_fm_cv  (i_in.lin_fm_cv),
        .i_amp_cv     (i_in.amp_cv),
        .i_sync_cv    (i_in.sync_cv),
        .i_pwm_cv     (i_in.pwm_cv),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out.valid),
        .o_sample_out (o_out.sample_out),
        .i_out_ready  (o_out.ready)
    );
endmodule
`default_nettype wire
